>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, sampled on the rising clock edge, off while in reset.
`define DTCT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that also holds while reset is asserted.
`define DTCT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> hdl/dtct_pkg.sv
// ----------------------------------------------------------------------------
// dtct_pkg
// Types, codes and character constants of the delimited text cell tokenizer.
// ----------------------------------------------------------------------------
package dtct_pkg;

    // Request on the input channel
    typedef struct packed {
        logic       func;       // 0 data byte, 1 end of flow
        logic [7:0] in_byte;
    } item_t;

    // Request on the output channel
    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] cell_byte;
    } result_t;

    // Decoder output toward the output stage
    typedef struct packed {
        logic    emit;
        result_t result;
    } dec_t;

    // Scanner mode
    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_ESCAPE  = 3'd1,
        MODE_SKIP_CR = 3'd2,
        MODE_SKIP_LF = 3'd3
    } scan_mode_t;

    // Token kinds
    localparam logic [2:0] KIND_DATA = 3'd0;
    localparam logic [2:0] KIND_SEP  = 3'd1;
    localparam logic [2:0] KIND_EOL  = 3'd2;
    localparam logic [2:0] KIND_EOF  = 3'd3;
    localparam logic [2:0] KIND_ERR  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_SEPARATOR = 1'b0;
    localparam logic CFG_ESCAPE    = 1'b1;

    // Configuration reset values
    localparam logic [7:0] SEPARATOR_RESET = 8'h09;
    localparam logic [7:0] ESCAPE_RESET    = 8'h5C;

    // Characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;

endpackage

>>> hdl/dtct_cfg_regs.sv
// ----------------------------------------------------------------------------
// dtct_cfg_regs
// Separator and escape character registers behind the plain write port.
// ----------------------------------------------------------------------------
module dtct_cfg_regs (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    output logic [7:0] separator_char,
    output logic [7:0] escape_char
);

    logic [7:0] separator_reg;
    logic [7:0] separator_next;
    logic [7:0] escape_reg;
    logic [7:0] escape_next;

    // Decode the write
    always_comb
    begin
        separator_next = separator_reg;
        escape_next    = escape_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                dtct_pkg::CFG_SEPARATOR: separator_next = cfg_data;
                dtct_pkg::CFG_ESCAPE:    escape_next    = cfg_data;
                default:                 separator_next = separator_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg <= dtct_pkg::SEPARATOR_RESET;
            escape_reg    <= dtct_pkg::ESCAPE_RESET;
        end
        else
        begin
            separator_reg <= separator_next;
            escape_reg    <= escape_next;
        end
    end

    assign separator_char = separator_reg;
    assign escape_char    = escape_reg;

endmodule

>>> hdl/dtct_in_stage.sv
// ----------------------------------------------------------------------------
// dtct_in_stage
// Input register: captures one request and holds it until the decoder takes it.
// ----------------------------------------------------------------------------
module dtct_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dtct_pkg::item_t     in_item,
    input  logic                advance,
    output logic                held_valid,
    output dtct_pkg::item_t     held_item
);

    logic            valid_reg;
    logic            valid_next;
    dtct_pkg::item_t item_reg;
    logic            accept;

    // Stall only while a held request cannot move on this cycle
    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        priority if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_item;
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

>>> hdl/dtct_decode.sv
// ----------------------------------------------------------------------------
// dtct_decode
// Scan mode machine: decides the token for the held byte combinationally.
// ----------------------------------------------------------------------------
module dtct_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  dtct_pkg::item_t     item,
    input  logic                advance,
    input  logic [7:0]          separator_char,
    input  logic [7:0]          escape_char,
    output dtct_pkg::dec_t      dec
);

    dtct_pkg::scan_mode_t mode_reg;
    dtct_pkg::scan_mode_t mode_next;
    logic [7:0]           b;
    logic                 is_escaped;
    logic                 swallow;

    assign b          = item.in_byte;
    assign is_escaped = (mode_reg == dtct_pkg::MODE_ESCAPE);

    // Partner byte of a line end just seen
    always_comb
    begin
        unique case (mode_reg)
            dtct_pkg::MODE_SKIP_CR: swallow = (b == dtct_pkg::CH_CR);
            dtct_pkg::MODE_SKIP_LF: swallow = (b == dtct_pkg::CH_LF);
            default:                swallow = 1'b0;
        endcase
    end

    // Next mode
    always_comb
    begin
        mode_next = dtct_pkg::MODE_NORMAL;
        priority if (item.func)
            mode_next = dtct_pkg::MODE_NORMAL;
        else if (is_escaped)
        begin
            priority if (b == dtct_pkg::CH_N || b == dtct_pkg::CH_R ||
                         b == dtct_pkg::CH_S || b == dtct_pkg::CH_T)
                mode_next = dtct_pkg::MODE_NORMAL;
            else if (b == dtct_pkg::CH_LF)
                mode_next = dtct_pkg::MODE_SKIP_CR;
            else if (b == dtct_pkg::CH_CR)
                mode_next = dtct_pkg::MODE_SKIP_LF;
            else
                mode_next = dtct_pkg::MODE_NORMAL;
        end
        else if (swallow)
            mode_next = dtct_pkg::MODE_NORMAL;
        else if (b == escape_char)
            mode_next = dtct_pkg::MODE_ESCAPE;
        else if (b == dtct_pkg::CH_LF)
            mode_next = dtct_pkg::MODE_SKIP_CR;
        else if (b == dtct_pkg::CH_CR)
            mode_next = dtct_pkg::MODE_SKIP_LF;
        else
            mode_next = dtct_pkg::MODE_NORMAL;
    end

    // Token for this byte
    always_comb
    begin
        dec.emit              = 1'b1;
        dec.result.token_kind = dtct_pkg::KIND_DATA;
        dec.result.cell_byte  = 8'h00;
        priority if (item.func)
            dec.result.token_kind = is_escaped ? dtct_pkg::KIND_ERR : dtct_pkg::KIND_EOF;
        else if (is_escaped)
        begin
            priority if (b == dtct_pkg::CH_N)
                dec.result.cell_byte = dtct_pkg::CH_LF;
            else if (b == dtct_pkg::CH_R)
                dec.result.cell_byte = dtct_pkg::CH_CR;
            else if (b == dtct_pkg::CH_S)
                dec.result.cell_byte = separator_char;
            else if (b == dtct_pkg::CH_T)
                dec.result.cell_byte = dtct_pkg::CH_TAB;
            else if (b == dtct_pkg::CH_LF || b == dtct_pkg::CH_CR ||
                     b == dtct_pkg::CH_TAB)
                dec.emit = 1'b0;    // line continuation, dropped tab
            else if (b == escape_char)
                dec.result.cell_byte = escape_char;
            else
                dec.result.token_kind = dtct_pkg::KIND_ERR;
        end
        else if (swallow)
            dec.emit = 1'b0;
        else if (b == escape_char)
            dec.emit = 1'b0;
        else if (b == dtct_pkg::CH_LF || b == dtct_pkg::CH_CR)
            dec.result.token_kind = dtct_pkg::KIND_EOL;
        else if (b == separator_char)
            dec.result.token_kind = dtct_pkg::KIND_SEP;
        else
            dec.result.cell_byte = b;
    end

    // Advance the mode with the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= dtct_pkg::MODE_NORMAL;
        else if (advance)
            mode_reg <= mode_next;
    end

endmodule

>>> hdl/dtct_out_stage.sv
// ----------------------------------------------------------------------------
// dtct_out_stage
// Output register: holds one token until the downstream side takes it.
// ----------------------------------------------------------------------------
module dtct_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  dtct_pkg::result_t   result,
    output logic                ready,
    output logic                out_valid,
    input  logic                out_stall,
    output dtct_pkg::result_t   out_item
);

    logic              valid_reg;
    logic              valid_next;
    dtct_pkg::result_t item_reg;

    // Room when empty or when the held token leaves this cycle
    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        priority if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= result;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> hdl/delimited_text_cell_tokenizer.sv
// ----------------------------------------------------------------------------
// delimited_text_cell_tokenizer
// Splits separator-delimited table text, one byte per request, into tokens:
// a cell data byte, a separator, an end of line, an end of file (on an
// end-of-flow request) or an error. Escape sequences give literal newline,
// return, tab, separator or escape bytes; an escaped line end continues the
// line. One request is taken every clock cycle unless in_stall is high; a
// token passes the input register, then the output register. The scan mode
// register is updated by the decoder in the same cycle it decides a byte.
// Bytes that give no token (escape, swallowed line-end partner, continuation)
// are consumed without using the output.
// Configuration writes are taken at any time and need no wait.
// ----------------------------------------------------------------------------
module delimited_text_cell_tokenizer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dtct_pkg::item_t     in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output dtct_pkg::result_t   out_item,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_data
);

    logic            held_valid;
    dtct_pkg::item_t held_item;
    dtct_pkg::dec_t  dec;
    logic            out_ready;
    logic            advance;
    logic [7:0]      separator_char;
    logic [7:0]      escape_char;

    // Move on when the token has room or there is no token
    assign advance = held_valid && (!dec.emit || out_ready);

    dtct_cfg_regs u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .separator_char (separator_char),
        .escape_char    (escape_char)
    );

    dtct_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    dtct_decode u_dec (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (held_item),
        .advance        (advance),
        .separator_char (separator_char),
        .escape_char    (escape_char),
        .dec            (dec)
    );

    dtct_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && dec.emit),
        .result    (dec.result),
        .ready     (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

>>> hdl/dtct_checker.sv
// ----------------------------------------------------------------------------
// dtct_checker
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtct_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input dtct_pkg::result_t   out_item
);

    // A stalled token holds
    `DTCT_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_item)), "stalled token changed")

    // Only defined kinds leave
    `DTCT_ASSERT(a_kind_range, clk, rst_n, out_valid |-> (out_item.token_kind <= dtct_pkg::KIND_ERR), "undefined token kind")

    // Non-data tokens carry a zero byte
    `DTCT_ASSERT(a_zero_byte, clk, rst_n, (out_valid && out_item.token_kind != dtct_pkg::KIND_DATA) |-> (out_item.cell_byte == 8'h00), "non-data token with nonzero byte")

    // An empty output never stalls the input
    `DTCT_ASSERT_ALWAYS(a_no_idle_stall, clk, !out_valid |-> !in_stall, "input stalled with empty output")

endmodule

bind delimited_text_cell_tokenizer dtct_checker u_checker (.*);
